// ===== src/tfb_pkg.sv =====
// Package with shared constants, types and the queue status for the frame builder.
`default_nettype none
package tfb_pkg;

    localparam int FRAME_LEN   = 10;
    localparam int COVERED_LEN = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int POS_W       = $clog2(FRAME_LEN);

    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_INIT   = 8'h00;
    localparam logic [7:0] SYNC_RESET = 8'hAA;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    // Covered bytes of one frame, index 0 is sent first.
    typedef logic [COVERED_LEN-1:0][7:0] t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

// ===== src/tfb_if.sv =====
// Valid/ready channel interfaces for telemetry records and frame bytes.
`default_nettype none
interface tfb_rec_if;
    logic               valid;
    logic               ready;
    logic [16:0]        rpm_value;
    logic [17:0]        batt_mv;
    logic signed [17:0] current_ma;
    logic [2:0]         status_flags;

    modport source (output valid, rpm_value, batt_mv, current_ma, status_flags,
                    input ready);
    modport sink   (input valid, rpm_value, batt_mv, current_ma, status_flags,
                    output ready);
endinterface

interface tfb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface
`default_nettype wire

// ===== src/tfb_front.sv =====
// Front end: accepts records, saturates the values and assembles the covered frame bytes.
`default_nettype none
module tfb_front
    import tfb_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [7:0] i_cfg_data,
    tfb_rec_if.sink    i_rec,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_frame     o_push_data
);

    logic [7:0]  r_sync;
    logic [7:0]  r_seq;
    logic [15:0] w_rpm;
    logic [15:0] w_mv;
    logic [15:0] w_ma;

    assign i_rec.ready = !i_q_status.full;
    assign o_push      = i_rec.valid && i_rec.ready;

    assign w_rpm = i_rec.rpm_value[16] ? 16'hFFFF : i_rec.rpm_value[15:0];
    assign w_mv  = (|i_rec.batt_mv[17:16]) ? 16'hFFFF : i_rec.batt_mv[15:0];

    // The current fits when its three top bits agree; otherwise clamp by sign.
    always_comb begin
        if ((i_rec.current_ma[17:15] == 3'b000) || (i_rec.current_ma[17:15] == 3'b111)) begin
            w_ma = i_rec.current_ma[15:0];
        end else if (i_rec.current_ma[17]) begin
            w_ma = 16'h8000;
        end else begin
            w_ma = 16'h7FFF;
        end
    end

    always_comb begin
        o_push_data[0] = r_sync;
        o_push_data[1] = r_seq;
        o_push_data[2] = w_rpm[7:0];
        o_push_data[3] = w_rpm[15:8];
        o_push_data[4] = w_mv[7:0];
        o_push_data[5] = w_mv[15:8];
        o_push_data[6] = w_ma[7:0];
        o_push_data[7] = w_ma[15:8];
        o_push_data[8] = {5'b00000, i_rec.status_flags};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
            r_seq  <= 8'h00;
        end else begin
            if (i_cfg_we) begin
                r_sync <= i_cfg_data;
            end
            if (o_push) begin
                r_seq <= r_seq + 8'h01;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/tfb_queue.sv =====
// Short queue of assembled frames between the front end and the serialiser.
`default_nettype none
module tfb_queue
    import tfb_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  t_frame     i_push_data,
    input  wire        i_pop,
    output t_frame     o_head,
    output t_q_status  o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/tfb_back.sv =====
// Serialiser: sends frame bytes one per cycle unless stalled, and appends the CRC-8.
`default_nettype none
module tfb_back
    import tfb_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_frame     i_head,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    tfb_byte_if.source o_byte
);

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_crc;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             w_load;
    logic             w_have;
    logic             w_is_crc;
    logic [7:0]       w_byte;
    logic [7:0]       w_crc_in;

    function automatic logic [7:0] crc8_absorb(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    assign w_is_crc = (r_pos == LAST_POS);
    assign w_load   = !r_out_valid || o_byte.ready;
    // The CRC byte needs nothing from the queue; data bytes need a frame at its head.
    assign w_have   = w_is_crc || !i_q_status.empty;
    assign o_pop    = w_load && w_is_crc;
    assign w_byte   = w_is_crc ? r_crc : i_head[r_pos];
    assign w_crc_in = (r_pos == '0) ? CRC_INIT : r_crc;

    assign o_byte.valid      = r_out_valid;
    assign o_byte.frame_byte = r_out_byte;
    assign o_byte.last_byte  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= w_have;
            if (w_have) begin
                r_pos <= w_is_crc ? '0 : r_pos + POS_W'(1);
                if (!w_is_crc) begin
                    r_crc <= crc8_absorb(w_crc_in, w_byte);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && w_have) begin
            r_out_byte <= w_byte;
            r_out_last <= w_is_crc;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("byte position beyond frame end");

    a_mid_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> r_out_valid)
        else $error("output register empty in the middle of a frame");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_pos == '0))
        else $error("last byte shown while position has not wrapped");

    a_pop_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_valid && r_out_last))
        else $error("frame released without the CRC byte being sent");

    a_data_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_is_crc && r_pos != '0) |-> !i_q_status.empty)
        else $error("queue emptied part way through a frame");

endmodule
`default_nettype wire

// ===== src/telemetry_frame_builder_crc8.sv =====
// A frame's first byte is offered after its record request is taken, written into the queue
// and then loaded into the serialiser's output register. Each frame is ten bytes, sent one
// byte per cycle while the output channel is ready; a two-frame queue lets the record side run ahead.
// Reset (synchronous, active low) sets the sync byte to 0xAA, the sequence number to zero
// and empties the queue and the serialiser.
`default_nettype none
module telemetry_frame_builder_crc8
    import tfb_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [7:0] i_cfg_data,
    tfb_rec_if.sink    i_rec,
    tfb_byte_if.source o_byte
);

    logic      w_push;
    t_frame    w_push_data;
    logic      w_pop;
    t_frame    w_head;
    t_q_status w_q_status;

    tfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_rec       (i_rec),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    tfb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_status    (w_q_status)
    );

    tfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_byte     (o_byte)
    );

endmodule
`default_nettype wire
